// ===== rtl/bvbe_pkg.sv =====
`timescale 1ns / 1ps

package bvbe_pkg;

    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 64;
    localparam int BYTE_W    = 8;
    localparam int GROUP_W   = 7;
    localparam int MAX_BYTES = 10;
    localparam int CNT_W     = $clog2(MAX_BYTES);

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_BYTES - 1);
    localparam logic [CNT_W-1:0] U32_LAST = CNT_W'(3);
    localparam logic [CNT_W-1:0] U64_LAST = CNT_W'(7);

    // bit 6 of a 7-bit group: the sign of the group for signed LEB128
    localparam int SIGN_POS = GROUP_W - 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE = 3'd0,
        CMD_U32  = 3'd1,
        CMD_U64  = 3'd2,
        CMD_ULEB = 3'd3,
        CMD_SLEB = 3'd4
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
    } t_shift_ctrl;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_digit_status;

endpackage

// ===== rtl/bvbe_if.sv =====
`timescale 1ns / 1ps

interface bvbe_in_if;
    logic                       valid;
    logic                       ready;
    logic [bvbe_pkg::CMD_W-1:0]   command;
    logic [bvbe_pkg::VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface bvbe_out_if;
    logic                        valid;
    logic                        ready;
    logic [bvbe_pkg::BYTE_W-1:0] out_byte;
    logic                        last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/bvbe_digit_shift.sv =====
`timescale 1ns / 1ps

module bvbe_digit_shift (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bvbe_pkg::t_shift_ctrl         i_ctrl,
    input  logic [bvbe_pkg::CMD_W-1:0]    i_command,
    input  logic [bvbe_pkg::VALUE_W-1:0]  i_value,
    output bvbe_pkg::t_digit_status       o_status
);
    import bvbe_pkg::*;

    logic [VALUE_W-1:0] r_value, n_value;
    t_cmd               r_cmd, n_cmd;
    logic [CNT_W-1:0]   r_count, n_count;

    logic [GROUP_W-1:0] low_group;
    logic               rest_zero;
    logic               rest_ones;
    logic               last;
    logic [BYTE_W-1:0]  out_byte;

    assign low_group = r_value[GROUP_W-1:0];
    assign rest_zero = ~|r_value[VALUE_W-1:GROUP_W];
    assign rest_ones = &r_value[VALUE_W-1:GROUP_W];

    // current digit and its end-of-run flag
    always_comb begin
        last     = 1'b1;
        out_byte = r_value[BYTE_W-1:0];
        case (r_cmd)
            CMD_BYTE: begin
                last = 1'b1;
            end
            CMD_U32: begin
                last = (r_count == U32_LAST);
            end
            CMD_U64: begin
                last = (r_count == U64_LAST);
            end
            CMD_ULEB: begin
                last     = rest_zero || (r_count == LAST_IDX);
                out_byte = {~last, low_group};
            end
            CMD_SLEB: begin
                last     = (rest_zero && !low_group[SIGN_POS]) ||
                           (rest_ones && low_group[SIGN_POS]) ||
                           (r_count == LAST_IDX);
                out_byte = {~last, low_group};
            end
            default: begin
                last = 1'b1;
            end
        endcase
    end

    assign o_status.out_byte = out_byte;
    assign o_status.last     = last;

    // load a new value, or shift out one digit per transfer
    always_comb begin
        n_value = r_value;
        n_cmd   = r_cmd;
        n_count = r_count;
        if (i_ctrl.load) begin
            n_value = i_value;
            n_cmd   = t_cmd'(i_command);
            n_count = '0;
        end else if (i_ctrl.advance) begin
            n_count = r_count + CNT_W'(1);
            case (r_cmd)
                CMD_ULEB: n_value = {{GROUP_W{1'b0}}, r_value[VALUE_W-1:GROUP_W]};
                CMD_SLEB: n_value = {{GROUP_W{r_value[VALUE_W-1]}},
                                     r_value[VALUE_W-1:GROUP_W]};
                default:  n_value = {{BYTE_W{1'b0}}, r_value[VALUE_W-1:BYTE_W]};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= CMD_BYTE;
            r_count <= '0;
        end else begin
            r_cmd   <= n_cmd;
            r_count <= n_count;
        end
        r_value <= n_value;
    end

endmodule

// ===== rtl/binary_value_byte_emitter_core.sv =====
`timescale 1ns / 1ps

// Value byte emitter: turns one 64-bit value and a format command into a
// run of bytes, least significant first, with last set on the final byte.
// Formats: raw byte (1), u32 LE (4), u64 LE (8), unsigned and signed
// LEB128 (1 to 10 bytes). Commands 5 to 7 are taken and produce nothing.
//
// Channels: i_cmd carries command and value, o_out carries out_byte and
// last; each moves one transfer when valid and ready are both high.
// Latency: the first byte is valid in the cycle after the command transfer.
// Throughput: one byte per cycle from the value shift register while the
// receiver is ready, then a pass through idle to load the next command;
// the longest item is a ten-byte LEB128 run.
// Reset (synchronous, active low) drops any run in progress and returns
// to idle with the command channel ready.
// When the receiver stalls, the current byte and last hold on o_out and
// the shift register does not advance; no new command is taken until the
// final byte of the run has been transferred.
module binary_value_byte_emitter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bvbe_in_if.sink     i_cmd,
    bvbe_out_if.source  o_out
);
    import bvbe_pkg::*;

    t_state        r_state, n_state;
    t_shift_ctrl   shift_ctrl;
    t_digit_status digit_status;
    logic          cmd_known;

    // commands outside the format set are dropped on transfer
    always_comb begin
        case (t_cmd'(i_cmd.command))
            CMD_BYTE, CMD_U32, CMD_U64, CMD_ULEB, CMD_SLEB: cmd_known = 1'b1;
            default:                                        cmd_known = 1'b0;
        endcase
    end

    // sequencer: idle waits for a command, emit streams its bytes
    always_comb begin
        n_state            = r_state;
        shift_ctrl.load    = 1'b0;
        shift_ctrl.advance = 1'b0;
        i_cmd.ready        = 1'b0;
        o_out.valid        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid && cmd_known) begin
                    shift_ctrl.load = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    shift_ctrl.advance = 1'b1;
                    // return to idle after the final byte's transfer
                    if (digit_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    bvbe_digit_shift u_digit_shift (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (shift_ctrl),
        .i_command (i_cmd.command),
        .i_value   (i_cmd.value),
        .o_status  (digit_status)
    );

    // payload comes straight from the held shift register state
    assign o_out.out_byte = digit_status.out_byte;
    assign o_out.last     = digit_status.last;

endmodule

// ===== bench/binary_value_byte_emitter_core_test.sv =====
`timescale 1ns / 1ps

// Checks the value byte emitter against its own encoder. Each command
// transfer is encoded into a queue of expected bytes, and each byte
// transfer on the output is compared with the oldest one. The sender works
// in bursts, and the receiver stalls in changing patterns. A long receiver
// hold makes the block back up onto its command channel.
module binary_value_byte_emitter_core_test;
    import bvbe_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 5;
    localparam int RANDOM_ITEMS     = 370;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 3 * MAX_BYTES;
    localparam int CYCLE_LIMIT      = 200_000;

    // Command codes outside the format set: taken by the block, no bytes out.
    localparam logic [CMD_W-1:0] RSVD_CMD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] RSVD_CMD_LAST  = 3'd7;

    // Byte encoder plus the queue of bytes still owed by the block.
    class emit_scoreboard;
        typedef struct packed {
            logic [BYTE_W-1:0] out_byte;
            logic              last;
        } owed_byte_t;

        owed_byte_t owed_bytes[$];
        int         mismatch_count;

        function void note_command(logic [CMD_W-1:0] command, logic [VALUE_W-1:0] value);
            logic [BYTE_W-1:0]         run[$];
            logic [BYTE_W-1:0]         grp;
            logic [VALUE_W-1:0]        rest;
            logic signed [VALUE_W-1:0] srest;
            int                        n_le;
            bit                        more;
            owed_byte_t                entry;

            n_le = 0;
            case (command)
                CMD_BYTE: n_le = 1;
                CMD_U32:  n_le = 4;
                CMD_U64:  n_le = 8;
                CMD_ULEB: begin
                    rest = value;
                    do begin
                        grp  = {1'b0, rest[GROUP_W-1:0]};
                        rest = rest >> GROUP_W;
                        if (rest != 0)
                            grp[BYTE_W-1] = 1'b1;
                        run.push_back(grp);
                    end while (rest != 0 && run.size() < MAX_BYTES);
                end
                CMD_SLEB: begin
                    // Stop once what is left is just the sign of the group.
                    srest = value;
                    more  = 1'b1;
                    while (more && run.size() < MAX_BYTES) begin
                        grp   = {1'b0, srest[GROUP_W-1:0]};
                        srest = srest >>> GROUP_W;
                        if ((srest == 0 && !grp[SIGN_POS]) || (srest == '1 && grp[SIGN_POS]))
                            more = 1'b0;
                        else
                            grp[BYTE_W-1] = 1'b1;
                        run.push_back(grp);
                    end
                end
                default: ;
            endcase
            for (int i = 0; i < n_le; i++)
                run.push_back(value[BYTE_W*i +: BYTE_W]);

            foreach (run[i]) begin
                entry.out_byte = run[i];
                entry.last     = (i == run.size() - 1);
                owed_bytes.push_back(entry);
            end
        endfunction

        function void check_byte(logic [BYTE_W-1:0] out_byte, logic last);
            owed_byte_t want;

            if (owed_bytes.size() == 0) begin
                $error("unexpected byte transfer: out_byte 0x%02h last %0b", out_byte, last);
                mismatch_count++;
                return;
            end
            want = owed_bytes.pop_front();
            if (out_byte !== want.out_byte) begin
                $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                       want.out_byte, out_byte);
                mismatch_count++;
            end
            if (last !== want.last) begin
                $error("last mismatch: expected %0b, actual %0b", want.last, last);
                mismatch_count++;
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bvbe_in_if  cmd_ch ();
    bvbe_out_if byte_ch ();

    binary_value_byte_emitter_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_out   (byte_ch)
    );

    emit_scoreboard sb = new();

    int cycle_count    = 0;
    int pattern_cycle  = 0;
    int stall_mode     = 0;
    int hold_left      = 0;
    int long_hold_reqs = 0;
    int long_hold_done = 0;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: check the byte moved at this edge, then pick the next ready.
    // A long hold is counted here once the sender asks for one.
    always @(posedge clk) begin
        if (byte_ch.valid && byte_ch.ready)
            sb.check_byte(byte_ch.out_byte, byte_ch.last);

        pattern_cycle++;
        if (long_hold_done != long_hold_reqs) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = long_hold_reqs;
        end

        if (!rst_n) begin
            byte_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            byte_ch.ready <= 1'b0;
        end else begin
            if (pattern_cycle % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       byte_ch.ready <= 1'b1;
                1:       byte_ch.ready <= 1'($urandom_range(0, 1));
                2:       byte_ch.ready <= (pattern_cycle % 3 != 0);
                default: byte_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Offer one command and hold it until the block takes it.
    task automatic send_item(input logic [CMD_W-1:0] command, input logic [VALUE_W-1:0] value);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= command;
        cmd_ch.value   <= value;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_command(command, value);
    endtask

    task automatic sender_idle(input int cycles);
        cmd_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop offering until every owed byte is out, then let the block settle.
    task automatic drain_owed_bytes();
        cmd_ch.valid <= 1'b0;
        while (sb.owed_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command();
        if ($urandom_range(0, 99) < 5)
            return CMD_W'($urandom_range(RSVD_CMD_FIRST, RSVD_CMD_LAST));
        return CMD_W'($urandom_range(CMD_BYTE, CMD_SLEB));
    endfunction

    // Spread values over every encoding length, both signs included.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        int                 k;

        v = {$urandom(), $urandom()};
        k = $urandom_range(0, VALUE_W - 1);
        case ($urandom_range(0, 3))
            0: ;
            1: v = v >> k;
            2: v = ~(v >> k);
            default: begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = '1;
                    2: v = 64'd1 << k;
                    3: v = (64'd1 << k) - 1;
                    default: v = -(64'd1 << k);
                endcase
            end
        endcase
        return v;
    endfunction

    // Send a run of format commands in bursts; reserved codes ride along
    // but do not count.
    task automatic send_random_items(input int count);
        logic [CMD_W-1:0] command;
        int               sent;
        int               burst;

        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < count; i++) begin
                command = pick_command();
                send_item(command, pick_value());
                if (command <= CMD_SLEB)
                    sent++;
            end
            if ($urandom_range(0, 3) != 0)
                sender_idle($urandom_range(1, 8));
        end
    endtask

    initial begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_BYTE;
        cmd_ch.value   = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every format, LEB128 length boundaries.
        send_item(CMD_BYTE, 64'h0);
        send_item(CMD_BYTE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_BYTE, 64'h1234_5678_9ABC_DE80);
        send_item(CMD_U32,  64'h0000_0000_FFFF_FFFF);
        send_item(CMD_U32,  64'hDEAD_BEEF_0123_4567);
        send_item(CMD_U64,  64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_U64,  64'h0123_4567_89AB_CDEF);
        send_item(CMD_U64,  64'h0);
        sender_idle(3);
        send_item(CMD_ULEB, 64'd0);
        send_item(CMD_ULEB, 64'd127);
        send_item(CMD_ULEB, 64'd128);
        send_item(CMD_ULEB, 64'd16383);
        send_item(CMD_ULEB, 64'd16384);
        send_item(CMD_ULEB, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_ULEB, 64'h8000_0000_0000_0000);
        send_item(CMD_SLEB, 64'd0);
        send_item(CMD_SLEB, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_SLEB, 64'd63);
        send_item(CMD_SLEB, 64'd64);
        send_item(CMD_SLEB, -64'sd64);
        send_item(CMD_SLEB, -64'sd65);
        send_item(CMD_SLEB, 64'h8000_0000_0000_0000);
        send_item(CMD_SLEB, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(RSVD_CMD_FIRST, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(RSVD_CMD_FIRST + 3'd1, 64'h0);
        send_item(RSVD_CMD_LAST, 64'h5555_AAAA_5555_AAAA);
        send_item(CMD_BYTE, 64'h7F);

        // Pause until the block has emitted everything it owes.
        drain_owed_bytes();

        send_random_items(RANDOM_ITEMS / 2);

        // Hold the receiver off and keep offering LEB128 runs back to
        // back, so the block fills and stalls the command channel.
        long_hold_reqs++;
        for (int i = 0; i < 40; i++)
            send_item(CMD_W'($urandom_range(CMD_ULEB, CMD_SLEB)), pick_value());

        send_random_items(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        drain_owed_bytes();

        if (sb.mismatch_count == 0 && sb.owed_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/bvbe_pkg.sv
rtl/bvbe_if.sv
rtl/bvbe_digit_shift.sv
rtl/binary_value_byte_emitter_core.sv
bench/binary_value_byte_emitter_core_test.sv
